// ===== hdl/qsle_pkg.sv =====
`default_nettype none
package qsle_pkg;

	localparam int DEPTH     = 64;
	localparam int WORD_BITS = 32;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = IDX_W + 1;
	localparam int SPAN_W    = 2 * CNT_W;

	localparam logic [CNT_W-1:0] CNT_ZERO = '0;
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	typedef struct packed {
		logic [CNT_W-1:0] lo;
		logic [CNT_W-1:0] hi;
	} span_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_POP,
		ST_POP_WAIT,
		ST_PIVOT_WAIT,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_FIN_RD,
		ST_FIN_A,
		ST_FIN_B,
		ST_EMIT_RD,
		ST_EMIT_WAIT
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/qsle_ram.sv =====
`default_nettype none
module qsle_ram #(
	parameter int ADDR_W = 6,
	parameter int DATA_W = 32
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_data_q <= mem_q[raddr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ===== hdl/quicksort_lomuto_engine_unit.sv =====
// Items are accepted while loading; the input is ready only while loading.
// After the item marked last, the set is sorted in place by one comparator and
// one element memory with a separate read port and write port.
// Results then leave in sorted order through a registered output that holds while m_tready is low.
// Reset (arst_n low, asynchronous) empties the set and the range stack; the
// element and range memories are not cleared and need no clearing pass.
`default_nettype none
module quicksort_lomuto_engine_unit
	import qsle_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [WORD_BITS-1:0] s_tdata,   // value[31:0]
	input  wire logic                 s_tlast,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [WORD_BITS-1:0] m_tdata,   // sorted_value[31:0]
	output logic                      m_tlast
);

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] sp_q, sp_d;
	logic [CNT_W-1:0] lo_q, lo_d;
	logic [CNT_W-1:0] hi_q, hi_d;
	logic [CNT_W-1:0] k_q, k_d;
	logic [CNT_W-1:0] slot_q, slot_d;
	logic [WORD_BITS-1:0] pivot_q, pivot_d;
	logic [WORD_BITS-1:0] tmp_q, tmp_d;
	logic out_valid_q, out_valid_d;
	logic out_last_q, out_last_d;
	logic [WORD_BITS-1:0] out_data_q, out_data_d;

	logic                 el_we;
	logic [IDX_W-1:0]     el_waddr;
	logic [WORD_BITS-1:0] el_wdata;
	logic [IDX_W-1:0]     el_raddr;
	logic [WORD_BITS-1:0] el_rdata;

	logic             st_we;
	logic [IDX_W-1:0] st_waddr;
	span_t            st_wdata;
	logic [IDX_W-1:0] st_raddr;
	span_t            st_rdata;

	logic [CNT_W-1:0] hi_m1;
	logic [CNT_W-1:0] stk_hi_m1;
	logic             less;
	logic             out_free;

	assign hi_m1     = hi_q - CNT_ONE;
	assign stk_hi_m1 = st_rdata.hi - CNT_ONE;
	assign less      = el_rdata < pivot_q;
	assign out_free  = !out_valid_q || m_tready;

	qsle_ram #(.ADDR_W(IDX_W), .DATA_W(WORD_BITS)) u_elem_ram (
		.clk     (clk),
		.we      (el_we),
		.waddr   (el_waddr),
		.wdata   (el_wdata),
		.raddr   (el_raddr),
		.rd_data (el_rdata)
	);

	qsle_ram #(.ADDR_W(IDX_W), .DATA_W(SPAN_W)) u_stack_ram (
		.clk     (clk),
		.we      (st_we),
		.waddr   (st_waddr),
		.wdata   (st_wdata),
		.raddr   (st_raddr),
		.rd_data (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= CNT_ZERO;
			sp_q        <= CNT_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			sp_q        <= sp_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q       <= lo_d;
		hi_q       <= hi_d;
		k_q        <= k_d;
		slot_q     <= slot_d;
		pivot_q    <= pivot_d;
		tmp_q      <= tmp_d;
		out_last_q <= out_last_d;
		out_data_q <= out_data_d;
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		sp_d        = sp_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		k_d         = k_q;
		slot_d      = slot_q;
		pivot_d     = pivot_q;
		tmp_d       = tmp_q;
		out_valid_d = out_valid_q && !m_tready;
		out_last_d  = out_last_q;
		out_data_d  = out_data_q;
		s_tready    = 1'b0;
		el_we       = 1'b0;
		el_waddr    = count_q[IDX_W-1:0];
		el_wdata    = s_tdata;
		el_raddr    = k_q[IDX_W-1:0];
		st_we       = 1'b0;
		st_waddr    = sp_q[IDX_W-1:0];
		st_wdata    = '{lo: CNT_ZERO, hi: count_q};
		st_raddr    = sp_q[IDX_W-1:0] - IDX_W'(1);

		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (count_q != CNT_FULL) begin
						el_we   = 1'b1;
						count_d = count_q + CNT_ONE;
					end
					if (s_tlast) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				sp_d = CNT_ZERO;
				if (count_q >= CNT_TWO) begin
					st_we    = 1'b1;
					st_waddr = '0;
					sp_d     = CNT_ONE;
				end
				state_d = ST_POP;
			end
			ST_POP: begin
				if (sp_q == CNT_ZERO) begin
					k_d     = CNT_ZERO;
					state_d = ST_EMIT_RD;
				end else begin
					sp_d    = sp_q - CNT_ONE;
					state_d = ST_POP_WAIT;
				end
			end
			ST_POP_WAIT: begin
				lo_d     = st_rdata.lo;
				hi_d     = st_rdata.hi;
				el_raddr = stk_hi_m1[IDX_W-1:0];
				state_d  = ST_PIVOT_WAIT;
			end
			ST_PIVOT_WAIT: begin
				pivot_d = el_rdata;
				k_d     = lo_q;
				slot_d  = lo_q;
				state_d = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				if (k_q == hi_m1) begin
					state_d = ST_FIN_RD;
				end else begin
					el_raddr = k_q[IDX_W-1:0];
					state_d  = ST_SCAN_CMP;
				end
			end
			ST_SCAN_CMP: begin
				tmp_d = el_rdata;
				if (less && k_q != slot_q) begin
					el_raddr = slot_q[IDX_W-1:0];
					state_d  = ST_SWAP_A;
				end else begin
					if (less) begin
						slot_d = slot_q + CNT_ONE;
					end
					k_d     = k_q + CNT_ONE;
					state_d = ST_SCAN_RD;
				end
			end
			ST_SWAP_A: begin
				el_we    = 1'b1;
				el_waddr = k_q[IDX_W-1:0];
				el_wdata = el_rdata;
				state_d  = ST_SWAP_B;
			end
			ST_SWAP_B: begin
				el_we    = 1'b1;
				el_waddr = slot_q[IDX_W-1:0];
				el_wdata = tmp_q;
				slot_d   = slot_q + CNT_ONE;
				k_d      = k_q + CNT_ONE;
				state_d  = ST_SCAN_RD;
			end
			ST_FIN_RD: begin
				el_raddr = slot_q[IDX_W-1:0];
				state_d  = ST_FIN_A;
			end
			ST_FIN_A: begin
				el_we    = 1'b1;
				el_waddr = hi_m1[IDX_W-1:0];
				el_wdata = el_rdata;
				st_wdata = '{lo: slot_q + CNT_ONE, hi: hi_q};
				if (hi_q > slot_q + CNT_TWO && sp_q != CNT_FULL) begin
					st_we = 1'b1;
					sp_d  = sp_q + CNT_ONE;
				end
				state_d = ST_FIN_B;
			end
			ST_FIN_B: begin
				el_we    = 1'b1;
				el_waddr = slot_q[IDX_W-1:0];
				el_wdata = pivot_q;
				st_wdata = '{lo: lo_q, hi: slot_q};
				if (slot_q > lo_q + CNT_ONE && sp_q != CNT_FULL) begin
					st_we = 1'b1;
					sp_d  = sp_q + CNT_ONE;
				end
				state_d = ST_POP;
			end
			ST_EMIT_RD: begin
				el_raddr = k_q[IDX_W-1:0];
				state_d  = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				el_raddr = k_q[IDX_W-1:0];
				if (out_free) begin
					out_valid_d = 1'b1;
					out_data_d  = el_rdata;
					out_last_d  = (k_q + CNT_ONE) == count_q;
					k_d         = k_q + CNT_ONE;
					if ((k_q + CNT_ONE) == count_q) begin
						count_d = CNT_ZERO;
						sp_d    = CNT_ZERO;
						state_d = ST_LOAD;
					end else begin
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire
